// ===== hw/rtl/assert_macros.svh =====
// Assertion helper macros shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ===== hw/rtl/acfg_pkg.sv =====
// Shared types, codes and constants of the actuator command frame generator
package acfg_pkg;

  // Configuration port geometry
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 3;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_NODE_ID  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_HOST_ID  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MAX_STEP = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_KP       = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_KD       = 3'd4;

  // Input item kinds
  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_TARGET = 2'd1;
  localparam logic [1:0] MODE_TOGGLE = 2'd2;
  localparam logic [1:0] MODE_RX     = 2'd3;

  // Frame type codes (id bits 28:24)
  localparam logic [4:0] TYPE_OPERATION = 5'h01;
  localparam logic [4:0] TYPE_ENABLE    = 5'h03;
  localparam logic [4:0] TYPE_STOP      = 5'h04;
  localparam logic [4:0] TYPE_READ      = 5'h11;

  localparam logic [15:0] FIXED_MID  = 16'h7FFF;
  localparam logic [15:0] READ_INDEX = 16'h7019;
  localparam logic [3:0]  LEN_FULL   = 4'd8;
  localparam logic [3:0]  LEN_EMPTY  = 4'd0;

  // Limits: 4*pi rad in Q16.16, kp and kd in 1/256 units
  localparam logic signed [31:0] POS_LIMIT = 32'sd823550;
  localparam logic [20:0]        KP_LIMIT  = 21'd1280000;
  localparam logic [15:0]        KD_LIMIT  = 16'd25600;

  // Tick counter runs 0..4
  localparam logic [2:0] PHASE_LAST = 3'd4;

  // Exact floor(x*num/den) as (x*ceil(2^k*num/den)) >> k over the value range.
  // Position: 32767/823550 reduces to 4681/117650.
  localparam int unsigned POS_SHIFT = 38;
  localparam logic [63:0] POS_RECIP_FULL =
    ((64'd1 << POS_SHIFT) * 64'd4681 + 64'd117649) / 64'd117650;
  localparam logic [33:0] POS_RECIP    = POS_RECIP_FULL[33:0];
  localparam logic [16:0] POS_RECIP_LO = POS_RECIP[16:0];
  localparam logic [16:0] POS_RECIP_HI = POS_RECIP[33:17];

  // kp: 65535/1280000 reduces to 13107/256000
  localparam int unsigned KP_SHIFT = 39;
  localparam logic [63:0] KP_RECIP_FULL =
    ((64'd1 << KP_SHIFT) * 64'd13107 + 64'd255999) / 64'd256000;
  localparam logic [34:0] KP_RECIP    = KP_RECIP_FULL[34:0];
  localparam logic [17:0] KP_RECIP_LO = KP_RECIP[17:0];
  localparam logic [16:0] KP_RECIP_HI = KP_RECIP[34:18];

  // kd: 65535/25600 reduces to 13107/5120
  localparam int unsigned KD_SHIFT = 28;
  localparam logic [63:0] KD_RECIP_FULL =
    ((64'd1 << KD_SHIFT) * 64'd13107 + 64'd5119) / 64'd5120;
  localparam logic [29:0] KD_RECIP = KD_RECIP_FULL[29:0];

  // Result queue depth
  localparam int unsigned FIFO_DEPTH_DEFAULT = 8;

  // Channel payloads
  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] new_target;
    logic [28:0]        rx_frame_id;
    logic [31:0]        rx_value;
  } in_item_t;

  typedef struct packed {
    logic [28:0] frame_id;
    logic [3:0]  frame_length;
    logic [63:0] frame_data;
    logic        last;
  } out_item_t;

  // Configuration register set
  typedef struct packed {
    logic [7:0]  node_id;
    logic [7:0]  host_id;
    logic [19:0] max_step;
    logic [20:0] proportional_gain;
    logic [15:0] damping_gain;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    node_id:           8'd127,
    host_id:           8'd253,
    max_step:          20'd11438,
    proportional_gain: 21'd10240,
    damping_gain:      16'd1280
  };

  // One bus frame
  typedef struct packed {
    logic [28:0] id;
    logic [3:0]  length;
    logic [63:0] data;
  } frame_t;

  // One queue entry: all frames caused by one input transaction
  typedef struct packed {
    logic   two;
    frame_t frame_a;
    frame_t frame_b;
  } fifo_entry_t;

  // State update stage -> multiply stage
  typedef struct packed {
    logic        op_en;
    logic        sec_en;
    logic [28:0] op_id;
    logic [28:0] sec_id;
    logic [3:0]  sec_len;
    logic [15:0] sec_data;
    logic [20:0] pos_off;
  } p1_t;

  // Multiply stage -> pack and queue
  typedef struct packed {
    logic        op_en;
    logic        sec_en;
    logic [28:0] op_id;
    logic [28:0] sec_id;
    logic [3:0]  sec_len;
    logic [15:0] sec_data;
    logic [37:0] pos_lo;
    logic [37:0] pos_hi;
    logic [38:0] kp_lo;
    logic [37:0] kp_hi;
    logic [44:0] kd_prod;
  } p2_t;

endpackage

// ===== hw/rtl/acfg_if.sv =====
// Valid/ready stream interfaces for the input and result channels
interface acfg_in_if;
  import acfg_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface acfg_out_if;
  import acfg_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/acfg_regs.sv =====
// APB-style configuration register file
module acfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [acfg_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [acfg_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [acfg_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  output acfg_pkg::cfg_t                    cfg
);
  import acfg_pkg::*;

  cfg_t                 cfg_r;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg     = cfg_r;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_NODE_ID:  cfg_r.node_id           <= pwdata[7:0];
        REG_HOST_ID:  cfg_r.host_id           <= pwdata[7:0];
        REG_MAX_STEP: cfg_r.max_step          <= pwdata[19:0];
        REG_KP:       cfg_r.proportional_gain <= pwdata[20:0];
        REG_KD:       cfg_r.damping_gain      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      REG_NODE_ID:  prdata = {24'd0, cfg_r.node_id};
      REG_HOST_ID:  prdata = {24'd0, cfg_r.host_id};
      REG_MAX_STEP: prdata = {12'd0, cfg_r.max_step};
      REG_KP:       prdata = {11'd0, cfg_r.proportional_gain};
      REG_KD:       prdata = {16'd0, cfg_r.damping_gain};
      default:      prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/acfg_core.sv =====
// Input register and actuator state update: slew, enable, target, measured position
`include "assert_macros.svh"
module acfg_core (
  input  logic           clk,
  input  logic           rst_n,
  acfg_in_if.sink        in_chan,
  input  logic           accept_ok,
  input  acfg_pkg::cfg_t cfg,
  output logic           in_busy,
  output logic           p1_valid,
  output acfg_pkg::p1_t  p1
);
  import acfg_pkg::*;

  localparam logic [7:0] EXP_UNIT = 8'd134;  // exponent where one LSB maps to 2^-16
  localparam logic [7:0] EXP_SAT  = 8'd142;  // from here on the magnitude is at least 2^31

  // float32 -> Q16.16, truncated toward zero, saturated, NaN gives zero
  function automatic logic signed [31:0] q16_from_float(input logic [31:0] bits);
    logic        sgn;
    logic [7:0]  ex;
    logic [22:0] man;
    logic [23:0] sig;
    logic [7:0]  sh;
    logic [31:0] mag;
    logic        sat;
    logic        nan;
    logic [31:0] res;
    sgn = bits[31];
    ex  = bits[30:23];
    man = bits[22:0];
    sig = {(ex != 8'd0), man};
    sat = 1'b0;
    nan = 1'b0;
    mag = '0;
    sh  = '0;
    if (ex == 8'hFF) begin
      if (man != 23'd0) nan = 1'b1;
      else sat = 1'b1;
    end else if (ex >= EXP_SAT) begin
      sat = 1'b1;
    end else if (ex >= EXP_UNIT) begin
      mag = {8'd0, sig} << (ex - EXP_UNIT);
    end else begin
      sh = EXP_UNIT - ((ex == 8'd0) ? 8'd1 : ex);
      if (sh < 8'd32) mag = {8'd0, sig} >> sh[4:0];
    end
    if (nan) res = '0;
    else if (sat) res = sgn ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else res = sgn ? (32'd0 - mag) : mag;
    return res;
  endfunction

  logic               in_valid_r;
  in_item_t           in_item_r;
  logic               in_fire;

  logic               enabled_r, enabled_nxt;
  logic signed [31:0] target_r, target_nxt;
  logic signed [31:0] setpoint_r, setpoint_nxt;
  logic signed [31:0] measured_r, measured_nxt;
  logic [2:0]         tick_phase_r, tick_phase_nxt;

  logic               p1_valid_r, p1_valid_nxt;
  p1_t                p1_r, p1_nxt;

  logic signed [32:0] diff;
  logic signed [32:0] step;
  logic signed [31:0] slewed;
  logic signed [31:0] clamped;
  logic [31:0]        pos_shift;
  logic [2:0]         phase_wrap;
  logic               rx_match;
  logic [28:0]        op_id;

  assign in_fire       = in_chan.valid && accept_ok;
  assign in_chan.ready = accept_ok;
  assign in_busy       = in_valid_r;
  assign p1_valid      = p1_valid_r;
  assign p1            = p1_r;

  // Slew limiter and position clamp
  always_comb begin
    diff = $signed({target_r[31], target_r}) - $signed({setpoint_r[31], setpoint_r});
    step = $signed({13'd0, cfg.max_step});
    if (diff > step) slewed = setpoint_r + $signed({12'd0, cfg.max_step});
    else if (diff < -step) slewed = setpoint_r - $signed({12'd0, cfg.max_step});
    else slewed = target_r;
    if (slewed > POS_LIMIT) clamped = POS_LIMIT;
    else if (slewed < -POS_LIMIT) clamped = -POS_LIMIT;
    else clamped = slewed;
    pos_shift = 32'(clamped + POS_LIMIT);
  end

  assign phase_wrap = (tick_phase_r >= PHASE_LAST) ? 3'd0 : tick_phase_r + 3'd1;
  assign rx_match   = (in_item_r.rx_frame_id[28:24] == TYPE_READ) &&
                      (in_item_r.rx_frame_id[15:8] == cfg.node_id);
  assign op_id      = {TYPE_OPERATION, FIXED_MID, cfg.node_id};

  // Per-transaction state update and frame selection
  always_comb begin
    enabled_nxt    = enabled_r;
    target_nxt     = target_r;
    setpoint_nxt   = setpoint_r;
    measured_nxt   = measured_r;
    tick_phase_nxt = tick_phase_r;
    p1_nxt         = '0;
    p1_nxt.op_id   = op_id;
    p1_nxt.pos_off = pos_shift[20:0];
    if (in_valid_r) begin
      case (in_item_r.mode)
        MODE_TICK: begin
          if (enabled_r) begin
            setpoint_nxt = slewed;
            p1_nxt.op_en = 1'b1;
          end
          tick_phase_nxt = phase_wrap;
          if (phase_wrap == 3'd0) begin
            p1_nxt.sec_en   = 1'b1;
            p1_nxt.sec_id   = {TYPE_READ, 8'h00, cfg.host_id, cfg.node_id};
            p1_nxt.sec_len  = LEN_FULL;
            p1_nxt.sec_data = READ_INDEX;
          end
        end
        MODE_TARGET: begin
          if (enabled_r) target_nxt = in_item_r.new_target;
        end
        MODE_TOGGLE: begin
          p1_nxt.sec_en  = 1'b1;
          p1_nxt.sec_len = LEN_EMPTY;
          if (!enabled_r) begin
            setpoint_nxt  = measured_r;
            target_nxt    = measured_r;
            enabled_nxt   = 1'b1;
            p1_nxt.sec_id = {TYPE_ENABLE, 8'h00, cfg.host_id, cfg.node_id};
          end else begin
            enabled_nxt   = 1'b0;
            p1_nxt.sec_id = {TYPE_STOP, 8'h00, cfg.host_id, cfg.node_id};
          end
        end
        MODE_RX: begin
          if (rx_match) measured_nxt = q16_from_float(in_item_r.rx_value);
        end
        default: ;
      endcase
    end
    p1_valid_nxt = p1_nxt.op_en || p1_nxt.sec_en;
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      enabled_r    <= 1'b0;
      target_r     <= '0;
      setpoint_r   <= '0;
      measured_r   <= '0;
      tick_phase_r <= '0;
      p1_valid_r   <= 1'b0;
    end else begin
      in_valid_r   <= in_fire;
      enabled_r    <= enabled_nxt;
      target_r     <= target_nxt;
      setpoint_r   <= setpoint_nxt;
      measured_r   <= measured_nxt;
      tick_phase_r <= tick_phase_nxt;
      p1_valid_r   <= p1_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) in_item_r <= in_chan.payload;
    p1_r <= p1_nxt;
  end

  `ASSERT_PROP(a_tick_sends_operation, clk, rst_n, (in_valid_r && in_item_r.mode == MODE_TICK && enabled_r) |=> (p1_valid_r && p1_r.op_en), "enabled tick produced no operation frame")
  `ASSERT_PROP(a_toggle_sends_one_frame, clk, rst_n, (in_valid_r && in_item_r.mode == MODE_TOGGLE) |=> (p1_valid_r && p1_r.sec_en && !p1_r.op_en), "toggle did not produce exactly one frame")

endmodule

// ===== hw/rtl/acfg_quant.sv =====
// Position and gain quantizer: reciprocal multiply stage, then combine and frame packing
module acfg_quant (
  input  logic                  clk,
  input  logic                  rst_n,
  input  acfg_pkg::cfg_t        cfg,
  input  logic                  p1_valid,
  input  acfg_pkg::p1_t         p1,
  output logic                  p2_busy,
  output logic                  push,
  output acfg_pkg::fifo_entry_t push_entry
);
  import acfg_pkg::*;

  logic        p2_valid_r;
  p2_t         p2_r, p2_nxt;
  logic [20:0] kp_c;
  logic [15:0] kd_c;
  logic [54:0] pos_sum;
  logic [55:0] kp_sum;
  logic [15:0] pos16, kp16, kd16;
  frame_t      op_frame, sec_frame;

  // Clamp gains and form partial products
  always_comb begin
    kp_c = (cfg.proportional_gain > KP_LIMIT) ? KP_LIMIT : cfg.proportional_gain;
    kd_c = (cfg.damping_gain > KD_LIMIT) ? KD_LIMIT : cfg.damping_gain;
    p2_nxt          = '0;
    p2_nxt.op_en    = p1.op_en;
    p2_nxt.sec_en   = p1.sec_en;
    p2_nxt.op_id    = p1.op_id;
    p2_nxt.sec_id   = p1.sec_id;
    p2_nxt.sec_len  = p1.sec_len;
    p2_nxt.sec_data = p1.sec_data;
    p2_nxt.pos_lo   = {17'd0, p1.pos_off} * {21'd0, POS_RECIP_LO};
    p2_nxt.pos_hi   = {17'd0, p1.pos_off} * {21'd0, POS_RECIP_HI};
    p2_nxt.kp_lo    = {18'd0, kp_c} * {21'd0, KP_RECIP_LO};
    p2_nxt.kp_hi    = {17'd0, kp_c} * {21'd0, KP_RECIP_HI};
    p2_nxt.kd_prod  = {29'd0, kd_c} * {15'd0, KD_RECIP};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) p2_valid_r <= 1'b0;
    else p2_valid_r <= p1_valid;
  end

  always_ff @(posedge clk) begin
    p2_r <= p2_nxt;
  end

  // Recombine halves and drop the fraction bits
  always_comb begin
    pos_sum = {p2_r.pos_hi, 17'd0} + {17'd0, p2_r.pos_lo};
    kp_sum  = {p2_r.kp_hi, 18'd0} + {17'd0, p2_r.kp_lo};
    pos16   = pos_sum[POS_SHIFT +: 16];
    kp16    = kp_sum[KP_SHIFT +: 16];
    kd16    = p2_r.kd_prod[KD_SHIFT +: 16];
  end

  // Frame packing, big-endian fields
  always_comb begin
    op_frame.id     = p2_r.op_id;
    op_frame.length = LEN_FULL;
    op_frame.data   = {kd16[7:0], kd16[15:8], kp16[7:0], kp16[15:8],
                       FIXED_MID[7:0], FIXED_MID[15:8], pos16[7:0], pos16[15:8]};
    sec_frame.id     = p2_r.sec_id;
    sec_frame.length = p2_r.sec_len;
    sec_frame.data   = {48'd0, p2_r.sec_data};
    push_entry.two     = p2_r.op_en && p2_r.sec_en;
    push_entry.frame_a = p2_r.op_en ? op_frame : sec_frame;
    push_entry.frame_b = sec_frame;
  end

  assign push    = p2_valid_r;
  assign p2_busy = p2_valid_r;

endmodule

// ===== hw/rtl/acfg_out_fifo.sv =====
// Result queue: an entry per framed input, a frame per cycle while ready, last on the final one
`include "assert_macros.svh"
module acfg_out_fifo #(
  parameter int unsigned DEPTH = acfg_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  acfg_pkg::fifo_entry_t push_entry,
  input  logic [1:0]            inflight,
  output logic                  accept_ok,
  acfg_out_if.source            out_chan
);
  import acfg_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned OCC_W = CNT_W + 2;

  fifo_entry_t      mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             sub_r;
  fifo_entry_t      head;
  frame_t           cur;
  logic             is_last;
  logic             fire;
  logic             pop;
  logic [OCC_W-1:0] occupancy;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // Credit check: every transaction still in the pipe may need an entry
  assign occupancy = OCC_W'(count_r) + OCC_W'(inflight);
  assign accept_ok = occupancy < OCC_W'(DEPTH);

  // Head entry and frame select
  assign head    = mem_r[rd_ptr_r];
  assign cur     = sub_r ? head.frame_b : head.frame_a;
  assign is_last = sub_r || !head.two;
  assign fire    = out_chan.valid && out_chan.ready;
  assign pop     = fire && is_last;

  assign out_chan.valid                = (count_r != '0);
  assign out_chan.payload.frame_id     = cur.id;
  assign out_chan.payload.frame_length = cur.length;
  assign out_chan.payload.frame_data   = cur.data;
  assign out_chan.payload.last         = is_last;

  // Pointers, fill count and frame index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      sub_r    <= 1'b0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop) rd_ptr_r <= ptr_inc(rd_ptr_r);
      count_r <= count_r + CNT_W'(push) - CNT_W'(pop);
      if (fire) sub_r <= !pop;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

  `ASSERT_NEVER(a_no_overflow, clk, rst_n, push && !pop && (count_r == CNT_W'(DEPTH)), "result queue overflow")
  `ASSERT_PROP(a_second_frame_valid, clk, rst_n, sub_r |-> (count_r != '0 && head.two), "second frame index on a single-frame entry")

endmodule

// ===== hw/rtl/actuator_command_frame_generator_top.sv =====
// Actuator command frame generator, top level.
// The first result frame is offered after the input register, the state update
//   register, the reciprocal multiply register and the result queue write.
// Throughput: one input transaction per cycle while the result queue has room; the
//   output moves one frame per cycle while out_chan.ready is high.
// Reset: rst_n synchronous, active low; register defaults, all state and queue cleared.
module actuator_command_frame_generator_top #(
  parameter int unsigned DEPTH = acfg_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  acfg_in_if.sink                         in_chan,
  acfg_out_if.source                      out_chan,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [acfg_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [acfg_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [acfg_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import acfg_pkg::*;

  cfg_t        cfg;
  logic        accept_ok;
  logic        in_busy;
  logic        p1_valid;
  p1_t         p1;
  logic        p2_busy;
  logic        push;
  fifo_entry_t push_entry;
  logic [1:0]  inflight;

  // Transactions between acceptance and the queue
  assign inflight = 2'(in_busy) + 2'(p1_valid) + 2'(p2_busy);

  acfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  acfg_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .accept_ok (accept_ok),
    .cfg       (cfg),
    .in_busy   (in_busy),
    .p1_valid  (p1_valid),
    .p1        (p1)
  );

  acfg_quant u_quant (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .p1_valid   (p1_valid),
    .p1         (p1),
    .p2_busy    (p2_busy),
    .push       (push),
    .push_entry (push_entry)
  );

  acfg_out_fifo #(
    .DEPTH (DEPTH)
  ) u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .inflight   (inflight),
    .accept_ok  (accept_ok),
    .out_chan   (out_chan)
  );

endmodule
